[rtl/dcwr_pkg.sv]
// Shared types and constants of the DMX channel window receiver.
`timescale 1ns / 1ps

package dcwr_pkg;

  // Default window size in channels.
  localparam int unsigned CHANNELS_DEF = 16;

  // Address field of a command covers the largest supported window.
  localparam int unsigned ADDR_W = 9;

  // Depth of the command queue between front and back.
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [9:0] SLOT_MAX = 10'd1023;

  // Operation codes of the input item.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes.
  localparam logic REG_START_ADDRESS = 1'b0;
  localparam logic REG_DOUBLE_READ   = 1'b1;

  // Register reset values.
  localparam logic [9:0] START_ADDRESS_RST = 10'd1;
  localparam logic       DOUBLE_READ_RST   = 1'b1;

  // One classified item on its way from front to back.
  typedef struct packed {
    logic              is_read;   // read item: return the accepted value
    logic              in_range;  // read item names a channel of the window
    logic              write;     // byte item that lands in the window
    logic              dbl;       // double-read mode at the time of the byte
    logic              sel;       // frame store selected for the byte
    logic [ADDR_W-1:0] addr;      // window index or channel index
    logic [7:0]        data;      // received byte
    logic [31:0]       btime;     // break tick after this item
  } cmd_t;

endpackage

[rtl/dmx_channel_window_receiver.sv]
// Top level of the DMX channel window receiver.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i / in_stall_o): one transfer per item. operation_i
//   selects a received-byte event (data_byte_i, framing_error_i, time_now_i) or
//   a channel read (channel_i, 1-based). Every item yields exactly one result.
//   Output channel (out_valid_o / out_stall_i): channel_value_o carries the
//   accepted value for a read (0 for a byte event or a channel outside the
//   window), last_frame_time_o the tick stamped at the latest break.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 start address, 1 double-read mode); write only while idle.
//   Path: command queue, then the read stage, then the result register.
//   Throughput: one item per cycle while in_stall_o is low; the front updates
//   slot counters, the back does one frame-store write and one accepted-value
//   write per cycle.
//   Reset: counters clear, then a clearing pass zeroes the three stores entry
//   by entry while in_stall_o stays high.
//   Output stall: the back pipeline holds; the four-entry command queue keeps
//   taking items until it fills, then in_stall_o rises.
module dmx_channel_window_receiver #(
  parameter int unsigned CHANNELS = dcwr_pkg::CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [7:0]  data_byte_i,
  input  logic        framing_error_i,
  input  logic [7:0]  channel_i,
  input  logic [31:0] time_now_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  channel_value_o,
  output logic [31:0] last_frame_time_o
);

  dcwr_pkg::cmd_t push_cmd, head_cmd;
  logic push, pop, q_full, q_empty, clear_busy;

  // Front: accept and classify, track slots and breaks.
  dcwr_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .operation_i,
    .data_byte_i,
    .framing_error_i,
    .channel_i,
    .time_now_i,
    .queue_full_i (q_full),
    .clear_busy_i (clear_busy),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  // Queue: decouple front stalls from back stalls.
  dcwr_fifo #(
    .DEPTH(dcwr_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_cmd_o (head_cmd),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  // Back: store updates, reads and the result register.
  dcwr_back #(
    .CHANNELS(CHANNELS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .queue_empty_i (q_empty),
    .head_cmd_i    (head_cmd),
    .pop_o         (pop),
    .clear_busy_o  (clear_busy),
    .out_valid_o,
    .out_stall_i,
    .channel_value_o,
    .last_frame_time_o
  );

endmodule

[rtl/dcwr_fifo.sv]
// Short command queue between the front and the back.
`timescale 1ns / 1ps

module dcwr_fifo #(
  parameter int unsigned DEPTH = dcwr_pkg::FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dcwr_pkg::cmd_t push_cmd_i,
  input  logic           pop_i,
  output dcwr_pkg::cmd_t head_cmd_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  dcwr_pkg::cmd_t      mem_q [DEPTH];
  logic [PW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]       count_q, count_d;
  logic                do_push, do_pop;

  assign full_o     = (count_q == CW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign head_cmd_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

[rtl/dcwr_front.sv]
// Front end: accept items, track slot position and breaks, classify into commands.
`timescale 1ns / 1ps

module dcwr_front #(
  parameter int unsigned CHANNELS = dcwr_pkg::CHANNELS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [9:0]     cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           operation_i,
  input  logic [7:0]     data_byte_i,
  input  logic           framing_error_i,
  input  logic [7:0]     channel_i,
  input  logic [31:0]    time_now_i,
  input  logic           queue_full_i,
  input  logic           clear_busy_i,
  output logic           push_o,
  output dcwr_pkg::cmd_t push_cmd_o
);

  localparam int unsigned WW = $clog2(CHANNELS + 1);
  localparam int unsigned CW = (WW > 8) ? WW : 8;

  logic [9:0]  start_q;
  logic        dbl_q;
  logic [9:0]  slot_q, slot_d;
  logic [WW-1:0] win_q, win_d;
  logic        sel_q, sel_d;
  logic [31:0] btime_q, btime_d;
  logic [10:0] last_slot;
  logic        hit;
  logic [CW-1:0] ch_m1;
  logic        accept;

  assign in_stall_o = queue_full_i || clear_busy_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = accept;

  assign last_slot = {1'b0, start_q} + 11'(CHANNELS - 1);
  assign hit = (slot_q >= start_q) && ({1'b0, slot_q} <= last_slot) &&
               (win_q < WW'(CHANNELS));
  assign ch_m1 = CW'(channel_i) - CW'(1);

  always_comb begin
    slot_d  = slot_q;
    win_d   = win_q;
    sel_d   = sel_q;
    btime_d = btime_q;
    push_cmd_o          = '0;
    push_cmd_o.is_read  = (operation_i == dcwr_pkg::OP_READ);
    push_cmd_o.dbl      = dbl_q;
    push_cmd_o.sel      = sel_q;
    push_cmd_o.data     = data_byte_i;
    if (operation_i == dcwr_pkg::OP_BYTE) begin
      push_cmd_o.write = hit;
      push_cmd_o.addr  = dcwr_pkg::ADDR_W'(win_q);
      if (hit) begin
        win_d = win_q + WW'(1);
      end
      if (slot_q < dcwr_pkg::SLOT_MAX) begin
        slot_d = slot_q + 10'd1;
      end
      // Break: the byte is stored first, then restart the frame.
      if (framing_error_i) begin
        btime_d = time_now_i;
        slot_d  = '0;
        win_d   = '0;
        sel_d   = ~sel_q;
      end
    end else begin
      push_cmd_o.in_range = (channel_i != 8'd0) && (10'(channel_i) <= 10'(CHANNELS));
      push_cmd_o.addr     = dcwr_pkg::ADDR_W'(ch_m1);
    end
    push_cmd_o.btime = btime_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= dcwr_pkg::START_ADDRESS_RST;
      dbl_q   <= dcwr_pkg::DOUBLE_READ_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dcwr_pkg::REG_START_ADDRESS: start_q <= cfg_data_i;
        dcwr_pkg::REG_DOUBLE_READ:   dbl_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      win_q   <= '0;
      sel_q   <= 1'b0;
      btime_q <= '0;
    end else if (accept) begin
      slot_q  <= slot_d;
      win_q   <= win_d;
      sel_q   <= sel_d;
      btime_q <= btime_d;
    end
  end

  a_win_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_q <= WW'(CHANNELS))
    else $error("window index past the window");

  a_break_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (operation_i == dcwr_pkg::OP_BYTE) && framing_error_i
    |=> (slot_q == '0) && (win_q == '0) && (sel_q != $past(sel_q)))
    else $error("break did not restart the frame");

endmodule

[rtl/dcwr_back.sv]
// Back end: frame stores, accepted values, clearing pass and result register.
`timescale 1ns / 1ps

module dcwr_back #(
  parameter int unsigned CHANNELS = dcwr_pkg::CHANNELS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           queue_empty_i,
  input  dcwr_pkg::cmd_t head_cmd_i,
  output logic           pop_o,
  output logic           clear_busy_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     channel_value_o,
  output logic [31:0]    last_frame_time_o
);

  localparam int unsigned IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [7:0] store_a [CHANNELS];
  logic [7:0] store_b [CHANNELS];
  logic [7:0] store_acc [CHANNELS];

  logic          clr_busy_q;
  logic [IW-1:0] clr_idx_q;

  logic           s1_v_q;
  dcwr_pkg::cmd_t s1_cmd_q;
  logic [7:0]     a_rd_q, b_rd_q, acc_rd_q;

  logic        out_v_q;
  logic [7:0]  cv_q;
  logic [31:0] lft_q;

  logic          adv, pop;
  logic [IW-1:0] pop_addr, s1_addr;
  logic          a_we, b_we, acc_we, commit;
  logic [IW-1:0] a_wa, b_wa, acc_wa;
  logic [7:0]    a_wd, b_wd, acc_wd;
  logic [7:0]    other;

  // Advance the whole pipeline unless a result is held by the receiver.
  assign adv      = !out_v_q || !out_stall_i;
  assign pop      = adv && !queue_empty_i && !clr_busy_q;
  assign pop_o    = pop;
  assign pop_addr = head_cmd_i.addr[IW-1:0];
  assign s1_addr  = s1_cmd_q.addr[IW-1:0];
  assign other    = s1_cmd_q.sel ? a_rd_q : b_rd_q;
  assign commit   = adv && s1_v_q && s1_cmd_q.write &&
                    (!s1_cmd_q.dbl || (s1_cmd_q.data == other));

  always_comb begin
    a_we   = pop && head_cmd_i.write && head_cmd_i.dbl && !head_cmd_i.sel;
    b_we   = pop && head_cmd_i.write && head_cmd_i.dbl && head_cmd_i.sel;
    a_wa   = pop_addr;
    b_wa   = pop_addr;
    a_wd   = head_cmd_i.data;
    b_wd   = head_cmd_i.data;
    acc_we = commit;
    acc_wa = s1_addr;
    acc_wd = s1_cmd_q.data;
    if (clr_busy_q) begin
      a_we   = 1'b1;
      b_we   = 1'b1;
      acc_we = 1'b1;
      a_wa   = clr_idx_q;
      b_wa   = clr_idx_q;
      acc_wa = clr_idx_q;
      a_wd   = '0;
      b_wd   = '0;
      acc_wd = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + IW'(1);
      if (clr_idx_q == IW'(CHANNELS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign clear_busy_o = clr_busy_q;

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      store_a[a_wa] <= a_wd;
    end
    if (b_we) begin
      store_b[b_wa] <= b_wd;
    end
    if (acc_we) begin
      store_acc[acc_wa] <= acc_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      a_rd_q <= store_a[pop_addr];
      b_rd_q <= store_b[pop_addr];
      if (acc_we && (acc_wa == pop_addr)) begin
        acc_rd_q <= acc_wd;
      end else begin
        acc_rd_q <= store_acc[pop_addr];
      end
      s1_cmd_q <= head_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= pop;
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_v_q) begin
      cv_q  <= (s1_cmd_q.is_read && s1_cmd_q.in_range) ? acc_rd_q : 8'd0;
      lft_q <= s1_cmd_q.btime;
    end
  end

  assign out_valid_o       = out_v_q;
  assign channel_value_o   = cv_q;
  assign last_frame_time_o = lft_q;

  a_no_work_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s1_v_q && !pop)
    else $error("item in flight during clearing pass");

  a_commit_only_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> !s1_cmd_q.is_read && adv)
    else $error("accepted value written by a read item");

endmodule

[tb/tb.sv]
// Self-checking testbench for the DMX channel window receiver.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CHANNELS = dcwr_pkg::CHANNELS_DEF;
  localparam int unsigned CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Idle wait after the last result has come back.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned REPORT_MAX = 10;

  // One input item as it crosses the input channel.
  typedef struct packed {
    logic        op;
    logic [7:0]  data;
    logic        brk;
    logic [7:0]  chan;
    logic [31:0] tick;
  } dmx_item_t;

  // One result item as it crosses the output channel.
  typedef struct packed {
    logic [7:0]  value;
    logic [31:0] tick;
  } dmx_result_t;

  // Every block input starts at a known value.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = dcwr_pkg::REG_START_ADDRESS;
  logic [9:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        operation_i = dcwr_pkg::OP_BYTE;
  logic [7:0]  data_byte_i = '0;
  logic        framing_error_i = 1'b0;
  logic [7:0]  channel_i = '0;
  logic [31:0] time_now_i = '0;
  logic        out_stall_i = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [7:0]  channel_value_o;
  logic [31:0] last_frame_time_o;

  dmx_channel_window_receiver #(
    .CHANNELS(CHANNELS)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .data_byte_i      (data_byte_i),
    .framing_error_i  (framing_error_i),
    .channel_i        (channel_i),
    .time_now_i       (time_now_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .channel_value_o  (channel_value_o),
    .last_frame_time_o(last_frame_time_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Shadow of the receiver: frame stores, accepted values, counters and
  // the two configuration registers, updated at every accepted transfer.
  // ---------------------------------------------------------------------
  logic [7:0]  frame_a [CHANNELS];
  logic [7:0]  frame_b [CHANNELS];
  logic [7:0]  accepted [CHANNELS];
  logic        sel_b;        // 1: bytes land in frame store b
  logic [9:0]  slot_pos;
  int unsigned win_idx;
  logic [31:0] break_tick;
  logic [9:0]  start_addr;
  logic        double_read;

  // Bookkeeping for the queues, the handshakes and the summary.
  dmx_item_t   queued_items [$];   // items still to be offered
  dmx_result_t due_results [$];    // results owed by the block, oldest first
  dmx_item_t   cur_item;           // item on the input port right now
  logic [7:0]  scene [1024];       // slot contents the simulated console sends
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  logic        send_quiet = 1'b0;
  logic        recv_quiet = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned break_count = 0;
  int unsigned read_count = 0;
  int unsigned setting_count = 0;

  function automatic void clear_shadow();
    for (int i = 0; i < CHANNELS; i++) begin
      frame_a[CIW'(i)] = '0;
      frame_b[CIW'(i)] = '0;
      accepted[CIW'(i)] = '0;
    end
    sel_b = 1'b0;
    slot_pos = '0;
    win_idx = 0;
    break_tick = '0;
    start_addr = dcwr_pkg::START_ADDRESS_RST;
    double_read = dcwr_pkg::DOUBLE_READ_RST;
  endfunction

  // Advance the shadow by one item and return the result it owes.
  function automatic dmx_result_t apply_dmx_item(input dmx_item_t it);
    dmx_result_t res;
    int unsigned last_slot;
    res.value = '0;
    if (it.op == dcwr_pkg::OP_BYTE) begin
      // The window end is taken in full width, so a start near 512 works.
      last_slot = start_addr + CHANNELS - 1;
      if (slot_pos >= start_addr && slot_pos <= last_slot && win_idx < CHANNELS) begin
        if (double_read) begin
          if (sel_b) frame_b[CIW'(win_idx)] = it.data;
          else frame_a[CIW'(win_idx)] = it.data;
          // Accept only when both frames agree on this slot.
          if (frame_a[CIW'(win_idx)] == frame_b[CIW'(win_idx)])
            accepted[CIW'(win_idx)] = frame_a[CIW'(win_idx)];
        end else begin
          accepted[CIW'(win_idx)] = it.data;
        end
        win_idx++;
      end
      if (slot_pos != dcwr_pkg::SLOT_MAX) slot_pos++;
      // A break byte is stored first, then it restarts the frame.
      if (it.brk) begin
        break_tick = it.tick;
        slot_pos = '0;
        win_idx = 0;
        sel_b = !sel_b;
        break_count++;
      end
    end else begin
      read_count++;
      if (it.chan != 0 && it.chan <= CHANNELS)
        res.value = accepted[CIW'(it.chan - 8'd1)];
    end
    res.tick = break_tick;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Input driver: offer queued items, with random idle gaps between them
  // and occasional stretches of back-to-back transfers.
  // ---------------------------------------------------------------------
  task automatic drive_item(input dmx_item_t it);
    cur_item        <= it;
    in_valid_i      <= 1'b1;
    operation_i     <= it.op;
    data_byte_i     <= it.data;
    framing_error_i <= it.brk;
    channel_i       <= it.chan;
    time_now_i      <= it.tick;
  endtask

  always @(posedge clk_i) begin : driver
    int unsigned gap;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        // Transfer at this edge: predict its result, then pick the next gap.
        due_results.push_back(apply_dmx_item(cur_item));
        items_sent++;
        if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 3);
        if (gap == 0 && queued_items.size() != 0) begin
          drive_item(queued_items.pop_front());
        end else begin
          in_valid_i <= 1'b0;
          send_gap <= (gap > 0) ? gap - 1 : 0;
        end
      end else if (!in_valid_i) begin
        if (send_gap != 0) send_gap <= send_gap - 1;
        else if (queued_items.size() != 0) drive_item(queued_items.pop_front());
      end
      // A stalled transfer simply holds its payload.
    end
  end

  // ---------------------------------------------------------------------
  // Output monitor: compare each transfer with the oldest expectation and
  // after every result stall the block for a randomly drawn time, possibly none.
  // ---------------------------------------------------------------------
  task automatic note_mismatch(input string what, input dmx_result_t want,
                               input dmx_result_t got);
    error_count++;
    if (error_count <= REPORT_MAX)
      $display("[%0t] %s: expected value %02h tick %08h, got value %02h tick %08h",
               $realtime, what, want.value, want.tick, got.value, got.tick);
  endtask

  always @(posedge clk_i) begin : monitor
    dmx_result_t want;
    dmx_result_t got;
    int unsigned hold;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        got.value = channel_value_o;
        got.tick = last_frame_time_o;
        if (due_results.size() == 0) begin
          note_mismatch("result with nothing expected", '0, got);
        end else begin
          want = due_results.pop_front();
          if (got.value !== want.value) note_mismatch("channel_value mismatch", want, got);
          if (got.tick !== want.tick) note_mismatch("last_frame_time mismatch", want, got);
        end
        if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
        hold = recv_quiet ? 0 : $urandom_range(0, 3);
        out_stall_i <= (hold != 0);
        stall_left <= hold;
      end else if (stall_left != 0) begin
        // Release the stall once the drawn number of cycles has passed.
        stall_left <= stall_left - 1;
        out_stall_i <= (stall_left > 1);
      end
    end
  end

  // Hard stop for a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] value, input logic brk, input logic [31:0] tick);
    dmx_item_t it;
    it.op = dcwr_pkg::OP_BYTE;
    it.data = value;
    it.brk = brk;
    it.chan = 8'($urandom_range(0, 255));
    it.tick = tick;
    queued_items.push_back(it);
  endtask

  // Read fields the block ignores carry random noise.
  task automatic push_read(input logic [7:0] chan);
    dmx_item_t it;
    it.op = dcwr_pkg::OP_READ;
    it.data = 8'($urandom_range(0, 255));
    it.brk = 1'($urandom_range(0, 1));
    it.chan = chan;
    it.tick = $urandom();
    queued_items.push_back(it);
  endtask

  // Mostly channels inside the window, sometimes channel 0 or beyond it.
  task automatic add_reads(input int unsigned count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) != 0) push_read(8'($urandom_range(1, CHANNELS)));
      else if ($urandom_range(0, 1) == 0) push_read(8'd0);
      else push_read(8'($urandom_range(CHANNELS + 1, 255)));
    end
  endtask

  // One DMX frame: break, start code, then slot data from the scene.
  // Short frames also get stray reads and the odd spurious break.
  task automatic add_frame(input int unsigned len);
    logic noisy;
    noisy = (len < 100);
    // Change a few slots so the two frame stores sometimes disagree.
    repeat ($urandom_range(0, 3))
      scene[10'($urandom_range(0, 1023))] = 8'($urandom_range(0, 255));
    push_byte(8'($urandom_range(0, 255)), 1'b1, $urandom());
    for (int s = 0; s < len; s++) begin
      if (noisy && $urandom_range(0, 24) == 0) add_reads(1);
      if (noisy && $urandom_range(0, 79) == 0)
        push_byte(8'($urandom_range(0, 255)), 1'b1, $urandom());
      push_byte(scene[10'(s)], 1'b0, $urandom());
    end
  endtask

  task automatic write_reg(input logic idx, input logic [9:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx == dcwr_pkg::REG_START_ADDRESS) start_addr = value;
    else double_read = value[0];
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every item has gone through and every result has come back.
  task automatic wait_idle();
    while (queued_items.size() != 0 || in_valid_i || due_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Drain the block, set both registers, then queue frames until roughly
  // count items.
  task automatic run_setting(input logic [9:0] start, input logic dbl,
                             input int unsigned count);
    logic [9:0] mode_word;
    int unsigned base;
    mode_word = 10'($urandom_range(0, 1023));
    mode_word[0] = dbl;
    wait_idle();
    write_reg(dcwr_pkg::REG_START_ADDRESS, start);
    write_reg(dcwr_pkg::REG_DOUBLE_READ, mode_word);
    setting_count++;
    base = items_sent + queued_items.size();
    while (items_sent + queued_items.size() < base + count) begin
      // Mostly whole windows, sometimes frames cut short.
      if ($urandom_range(0, 4) == 0) add_frame($urandom_range(0, start + CHANNELS));
      else add_frame(start + CHANNELS + $urandom_range(0, 4));
      add_reads($urandom_range(2, 6));
    end
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    clear_shadow();
    for (int s = 0; s < 1024; s++) scene[10'(s)] = 8'($urandom_range(0, 255));

    // Directed part at reset settings: start address 1, double read.
    // Reads straight after reset, including out-of-range channels.
    push_read(8'd0);
    push_read(8'd1);
    push_read(8'(CHANNELS));
    push_read(8'(CHANNELS + 1));
    push_read(8'd255);
    // Break with an all-ones tick, then a frame into store b.
    push_byte(8'hFF, 1'b1, 32'hFFFF_FFFF);
    push_byte(8'h00, 1'b0, 32'h0);
    push_byte(8'hFF, 1'b0, 32'h0);
    push_byte(8'h00, 1'b0, 32'h0);
    push_byte(8'h5A, 1'b0, 32'h0);
    // The break byte itself lands in the window before the restart.
    push_byte(8'h80, 1'b1, 32'h1234_5678);
    // Second frame into store a: channel 1 and 3 agree, channel 2 does not.
    push_byte(8'h00, 1'b0, 32'hFFFF_FFFF);
    push_byte(8'hFF, 1'b0, 32'h0);
    push_byte(8'h01, 1'b0, 32'h0);
    push_byte(8'h5A, 1'b0, 32'h0);
    push_byte(8'h80, 1'b1, 32'h0);
    push_read(8'd1);
    push_read(8'd2);
    push_read(8'd3);
    push_read(8'd4);
    push_read(8'(CHANNELS));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    // Random part over a range of settings, extremes included.
    run_setting(10'd0, 1'b0, 50);
    run_setting(10'd1, 1'b1, 60);
    run_setting(10'($urandom_range(2, 24)), 1'b1, 60);
    run_setting(10'($urandom_range(0, 30)), 1'b0, 50);
    // Window above the 8-bit address range: one full frame in plain mode.
    wait_idle();
    write_reg(dcwr_pkg::REG_START_ADDRESS, 10'd270);
    write_reg(dcwr_pkg::REG_DOUBLE_READ, 10'd0);
    setting_count++;
    add_frame(270 + CHANNELS + 2);
    add_reads(8);
    run_setting(10'($urandom_range(0, 12)), 1'b1, 50);
    wait_idle();

    $display("Ran %0d transfers over %0d register settings: %0d breaks, %0d channel reads.",
             items_sent, setting_count, break_count, read_count);
    $display("Compared %0d results, %0d mismatches.", results_seen, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[dmx_channel_window_receiver.f]
rtl/dcwr_pkg.sv
rtl/dcwr_fifo.sv
rtl/dcwr_front.sv
rtl/dcwr_back.sv
rtl/dmx_channel_window_receiver.sv
tb/tb.sv
